[hw/rtl/pwi_pkg.sv]
`timescale 1ns / 1ps
package pwi_pkg;

  // One input word and one result word.
  typedef struct packed {
    logic signed [31:0] measured_value;
    logic               restart;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] error_now;
    logic signed [31:0] integral_now;
  } out_word_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TARGET = 3'd0;
  localparam logic [2:0] CFG_LIMIT  = 3'd1;
  localparam logic [2:0] CFG_GAIN_P = 3'd2;
  localparam logic [2:0] CFG_GAIN_I = 3'd3;
  localparam logic [2:0] CFG_GAIN_D = 3'd4;
  localparam logic [2:0] CFG_PERIOD = 3'd5;

  // Divider steps: the dividend is a 33 bit magnitude shifted up by 24.
  localparam int DIV_STEPS = 57;

  typedef enum logic [1:0] {MUL_NONE, MUL_P, MUL_D, MUL_I} mul_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     calc_err;
    logic     clear;
    logic     prep;
    logic     step;
    logic     term;
    logic     integ;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fresh;
    logic out_free;
  } status_t;

  // Give a sign to a magnitude and saturate to 32 bits.
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] m);
    logic signed [31:0] r;
    if (neg) begin
      if (m >= 64'h8000_0000) r = 32'sh8000_0000;
      else r = -$signed(m[31:0]);
    end else begin
      if (m >= 64'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = $signed(m[31:0]);
    end
    return r;
  endfunction

  // Saturate a 33 bit signed value to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[hw/rtl/pid_windowed_integral.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_stall    measured_value, restart
// out      output     out_valid / out_stall  drive, error_now, integral_now
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// A normal word passes the error and check states, the 57 step restoring divider
// for the derivative, the term and integral states and the multiply states before
// its result is offered; a fresh start skips divider, term and integral. The next
// word can be taken in the first cycle its predecessor's result is offered.
// One word is processed at a time; in_stall is high while it is in flight, and
// a finished word is held back while the previous result is still stalled.
// Reset (rst, synchronous) clears control state at once; no clearing pass.
module pid_windowed_integral #(
  parameter int WINDOW_LEN = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pwi_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pwi_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] target_value, gain_p, gain_i, gain_d;
  logic [30:0]        output_limit;
  logic [31:0]        sample_period;
  pwi_pkg::cmd_t      cmd;
  pwi_pkg::status_t   status;
  logic               busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_value  <= '0;
      output_limit  <= 31'd6553600;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      sample_period <= 32'd279609;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwi_pkg::CFG_TARGET: target_value  <= cfg_data;
        pwi_pkg::CFG_LIMIT:  output_limit  <= cfg_data[30:0];
        pwi_pkg::CFG_GAIN_P: gain_p        <= cfg_data;
        pwi_pkg::CFG_GAIN_I: gain_i        <= cfg_data;
        pwi_pkg::CFG_GAIN_D: gain_d        <= cfg_data;
        pwi_pkg::CFG_PERIOD: sample_period <= cfg_data;
        default: ;
      endcase
    end
  end

  pwi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  pwi_dp #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_data       (in_data),
    .target_value  (target_value),
    .output_limit  (output_limit),
    .gain_p        (gain_p),
    .gain_i        (gain_i),
    .gain_d        (gain_d),
    .sample_period (sample_period),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

  assign in_stall = busy;

endmodule

[hw/rtl/pwi_ram.sv]
`timescale 1ns / 1ps
module pwi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pwi_ctrl.sv]
`timescale 1ns / 1ps
module pwi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  pwi_pkg::status_t status,
  output pwi_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_CHK, S_ITER, S_TERM, S_INTEG,
    S_M0, S_M1, S_M2, S_M3, S_DONE
  } state_t;

  localparam logic [5:0] LAST_STEP = 6'(pwi_pkg::DIV_STEPS - 1);

  state_t     state;
  logic [5:0] cnt;

  // Sequencer state and the step counter of the divide loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_ERR;
        S_ERR:   state <= S_CHK;
        S_CHK: begin
          cnt   <= '0;
          state <= status.fresh ? S_M0 : S_ITER;
        end
        S_ITER: begin
          cnt <= cnt + 6'd1;
          if (cnt == LAST_STEP) state <= S_TERM;
        end
        S_TERM:  state <= S_INTEG;
        S_INTEG: state <= S_M0;
        S_M0:    state <= S_M1;
        S_M1:    state <= S_M2;
        S_M2:    state <= S_M3;
        S_M3:    state <= S_DONE;
        S_DONE:  if (status.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd = '0;
    cmd.mul_sel = pwi_pkg::MUL_NONE;
    cmd.acc_op  = pwi_pkg::ACC_HOLD;
    unique case (state)
      S_IDLE:  cmd.load = in_valid;
      S_ERR:   cmd.calc_err = 1'b1;
      S_CHK: begin
        cmd.clear = status.fresh;
        cmd.prep  = !status.fresh;
      end
      S_ITER:  cmd.step = 1'b1;
      S_TERM:  cmd.term = 1'b1;
      S_INTEG: cmd.integ = 1'b1;
      S_M0:    cmd.mul_sel = pwi_pkg::MUL_P;
      S_M1: begin
        cmd.mul_sel = pwi_pkg::MUL_D;
        cmd.acc_op  = pwi_pkg::ACC_LOAD;
      end
      S_M2: begin
        cmd.mul_sel = pwi_pkg::MUL_I;
        cmd.acc_op  = pwi_pkg::ACC_ADD;
      end
      S_M3:    cmd.acc_op = pwi_pkg::ACC_ADD;
      S_DONE:  cmd.emit = status.out_free;
      default: cmd = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[hw/rtl/pwi_dp.sv]
`timescale 1ns / 1ps
module pwi_dp #(
  parameter int WINDOW_LEN = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  pwi_pkg::cmd_t       cmd,
  output pwi_pkg::status_t    status,
  input  pwi_pkg::in_word_t   in_data,
  input  logic signed [31:0]  target_value,
  input  logic [30:0]         output_limit,
  input  logic signed [31:0]  gain_p,
  input  logic signed [31:0]  gain_i,
  input  logic signed [31:0]  gain_d,
  input  logic [31:0]         sample_period,
  output logic                out_valid,
  input  logic                out_stall,
  output pwi_pkg::out_word_t  out_data
);

  localparam int SW = $clog2(WINDOW_LEN);
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW_LEN - 1);

  pwi_pkg::in_word_t  in_reg;
  logic               pending;
  logic signed [31:0] err, prev_err, deriv, integ;
  logic [SW-1:0]      slot, slot_next;
  logic [WINDOW_LEN-1:0] valid;
  logic               d_neg, s_neg;
  logic [31:0]        per, rem;
  logic [56:0]        dq;
  logic [64:0]        mcand, macc;
  logic [31:0]        mplier;
  logic signed [63:0] prod;
  logic signed [49:0] acc;
  logic [31:0]        old_term;
  logic signed [31:0] term_val, deriv_val;

  logic signed [32:0] diff, sum;
  logic [32:0]        rem_sh;
  logic               qbit;
  logic signed [63:0] prod_rnd;
  logic signed [49:0] prod_q, lim_e, drive_e;
  logic signed [31:0] mul_a, mul_b, old_val;

  assign slot_next = (slot == LAST_SLOT) ? '0 : slot + SW'(1);
  assign diff = 33'(err) - 33'(prev_err);
  assign sum  = 33'(err) + 33'(prev_err);

  // Window store; an entry without its valid bit reads as zero.
  pwi_ram #(.WIDTH(32), .DEPTH(WINDOW_LEN)) u_ram (
    .clk   (clk),
    .we    (cmd.term),
    .waddr (slot),
    .wdata (term_val),
    .raddr (slot_next),
    .rdata (old_term)
  );
  assign old_val = valid[slot_next] ? $signed(old_term) : 32'sd0;

  // One restoring divide step.
  assign rem_sh = {rem, dq[56]};
  assign qbit   = (rem_sh >= {1'b0, per});

  // Finished term and derivative.
  assign deriv_val = pwi_pkg::sat_mag(d_neg, {7'd0, dq});
  assign term_val  = pwi_pkg::sat_mag(s_neg, {24'd0, macc[64:25]});

  // Shared gain multiplier operands.
  always_comb begin
    unique case (cmd.mul_sel)
      pwi_pkg::MUL_P: begin mul_a = gain_p; mul_b = err; end
      pwi_pkg::MUL_D: begin mul_a = gain_d; mul_b = deriv; end
      pwi_pkg::MUL_I: begin mul_a = gain_i; mul_b = integ; end
      default:        begin mul_a = '0;     mul_b = '0; end
    endcase
  end

  // Product truncated toward zero to Q16.16.
  assign prod_rnd = prod + (prod[63] ? 64'sd65535 : 64'sd0);
  assign prod_q   = 50'(prod_rnd >>> 16);

  // Clamp to the symmetric limit.
  assign lim_e = $signed({19'd0, output_limit});
  always_comb begin
    if (acc > lim_e) drive_e = lim_e;
    else if (acc < -lim_e) drive_e = -lim_e;
    else drive_e = acc;
  end

  assign status.fresh    = in_reg.restart || pending;
  assign status.out_free = !out_valid || !out_stall;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b1;
      valid     <= '0;
      slot      <= '0;
      integ     <= '0;
      prev_err  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        pending  <= 1'b0;
        valid    <= '0;
        slot     <= '0;
        integ    <= '0;
        prev_err <= err;
      end
      if (cmd.term) begin
        valid[slot] <= 1'b1;
        integ       <= pwi_pkg::sat33(33'(integ) + 33'(term_val));
        prev_err    <= err;
      end
      if (cmd.integ) begin
        integ <= pwi_pkg::sat33(33'(integ) - 33'(old_val));
        slot  <= slot_next;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.load) in_reg <= in_data;
    if (cmd.calc_err)
      err <= pwi_pkg::sat33(33'(target_value) - 33'(in_reg.measured_value));
    if (cmd.clear) deriv <= '0;
    if (cmd.prep) begin
      d_neg  <= diff[32];
      s_neg  <= sum[32];
      per    <= (sample_period == '0) ? 32'd1 : sample_period;
      rem    <= '0;
      dq     <= {(diff[32] ? 33'(-diff) : 33'(diff)), 24'd0};
      mcand  <= {32'd0, (sum[32] ? 33'(-sum) : 33'(sum))};
      mplier <= (sample_period == '0) ? 32'd1 : sample_period;
      macc   <= '0;
    end
    if (cmd.step) begin
      rem    <= qbit ? 32'(rem_sh - {1'b0, per}) : rem_sh[31:0];
      dq     <= {dq[55:0], qbit};
      if (mplier[0]) macc <= macc + mcand;
      mcand  <= {mcand[63:0], 1'b0};
      mplier <= {1'b0, mplier[31:1]};
    end
    if (cmd.term) deriv <= deriv_val;
    prod <= 64'(mul_a) * 64'(mul_b);
    unique case (cmd.acc_op)
      pwi_pkg::ACC_LOAD: acc <= prod_q;
      pwi_pkg::ACC_ADD:  acc <= acc + prod_q;
      default:           acc <= acc;
    endcase
    if (cmd.emit) begin
      out_data.drive        <= drive_e[31:0];
      out_data.error_now    <= err;
      out_data.integral_now <= integ;
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int WIN = 20;
  localparam int N_RANDOM = 800;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  pwi_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  pwi_pkg::out_word_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  pid_windowed_integral #(.WINDOW_LEN(WIN)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Controller model state and register copies.
  logic signed [31:0] m_target;
  logic [30:0] m_limit;
  logic signed [31:0] m_kp, m_ki, m_kd;
  logic [31:0] m_period;
  logic signed [31:0] m_prev_err;
  logic signed [31:0] m_window [WIN];
  logic signed [31:0] m_integral;
  int m_slot;
  bit m_fresh;

  pwi_pkg::out_word_t expected_words[$];
  int n_fail;
  int n_checked;
  int n_sent;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [31:0] sat_to32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Q16.16 product truncated toward zero.
  function automatic logic signed [65:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [65:0] p;
    logic [65:0] m;
    p = 66'(a) * 66'(b);
    m = (p < 0) ? 66'(-p) : 66'(p);
    m = m >> 16;
    return (p < 0) ? -$signed(m) : $signed(m);
  endfunction

  // Apply one sample to the controller model and return the result word.
  function automatic pwi_pkg::out_word_t pid_step(input pwi_pkg::in_word_t w);
    pwi_pkg::out_word_t r;
    logic signed [65:0] d, s, drv, lim;
    logic [95:0] dm, sm;
    logic [31:0] per;
    logic signed [31:0] err, deriv, term;
    int nxt;
    per = (m_period == 0) ? 32'd1 : m_period;
    err = sat_to32(66'(m_target) - 66'(w.measured_value));
    deriv = 0;
    if (w.restart || m_fresh) begin
      for (int i = 0; i < WIN; i++) m_window[i] = 0;
      m_integral = 0;
      m_slot = 0;
      m_fresh = 0;
    end else begin
      d = 66'(err) - 66'(m_prev_err);
      s = 66'(err) + 66'(m_prev_err);
      dm = (96'((d < 0) ? -d : d) << 24) / 96'(per);
      sm = (96'((s < 0) ? -s : s) * 96'(per)) >> 25;
      deriv = pwi_pkg::sat_mag(d < 0,
                               64'(dm > 96'hFFFF_FFFF_FFFF ? 96'hFFFF_FFFF_FFFF : dm));
      term = pwi_pkg::sat_mag(s < 0,
                              64'(sm > 96'hFFFF_FFFF_FFFF ? 96'hFFFF_FFFF_FFFF : sm));
      nxt = (m_slot + 1) % WIN;
      m_window[m_slot] = term;
      m_integral = sat_to32(66'(m_integral) + 66'(term));
      m_integral = sat_to32(66'(m_integral) - 66'(m_window[nxt]));
      m_slot = nxt;
    end
    m_prev_err = err;
    drv = qmul(m_kp, err) + qmul(m_kd, deriv) + qmul(m_ki, m_integral);
    lim = 66'(m_limit);
    if (drv > lim) drv = lim;
    if (drv < -lim) drv = -lim;
    r.drive = drv[31:0];
    r.error_now = err;
    r.integral_now = m_integral;
    return r;
  endfunction

  // Result checker and watchdog on the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word drive=%0d", out_data.drive);
          n_fail++;
        end else begin
          pwi_pkg::out_word_t e;
          e = expected_words.pop_front();
          n_checked++;
          if (out_data.drive !== e.drive) begin
            $error("drive: expected %0d actual %0d", e.drive, out_data.drive);
            n_fail++;
          end
          if (out_data.error_now !== e.error_now) begin
            $error("error_now: expected %0d actual %0d", e.error_now, out_data.error_now);
            n_fail++;
          end
          if (out_data.integral_now !== e.integral_now) begin
            $error("integral_now: expected %0d actual %0d", e.integral_now,
                   out_data.integral_now);
            n_fail++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("pid_windowed_integral regression: fail");
        $finish;
      end
    end
  end

  // Receiver stall: a random number of stalled cycles before each word.
  initial begin
    int waits;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (waits > 0) begin
        out_stall <= 1'b1;
        repeat (waits) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      pwi_pkg::CFG_TARGET: m_target = val;
      pwi_pkg::CFG_LIMIT: m_limit = val[30:0];
      pwi_pkg::CFG_GAIN_P: m_kp = val;
      pwi_pkg::CFG_GAIN_I: m_ki = val;
      pwi_pkg::CFG_GAIN_D: m_kd = val;
      pwi_pkg::CFG_PERIOD: m_period = val;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Send one word after an optional gap; returns once the block takes it.
  // The valid stays high with the taken word until the next call or a drain,
  // which is safe because the block is busy with that word meanwhile.
  task automatic send_sample(input pwi_pkg::in_word_t w, input bit gaps);
    int waits;
    waits = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : 0;
    if (waits > 0) begin
      in_valid <= 1'b0;
      repeat (waits) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(pid_step(w));
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 65535) << $urandom_range(0, 16);
      3: return -($urandom_range(0, 65535) << $urandom_range(0, 16));
      default: return $urandom();
    endcase
  endfunction

  typedef struct {
    logic signed [31:0] meas;
    bit restart;
    bit known;
    pwi_pkg::out_word_t want;
  } dir_row_t;

  initial begin
    dir_row_t rows[12];
    pwi_pkg::in_word_t w;
    pwi_pkg::out_word_t got;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = pwi_pkg::CFG_TARGET;
    cfg_data = '0;
    n_fail = 0;
    n_checked = 0;
    n_sent = 0;
    m_target = 0; m_limit = 31'd6553600; m_kp = 0; m_ki = 0; m_kd = 0;
    m_period = 32'd279609; m_prev_err = 0; m_integral = 0; m_slot = 0; m_fresh = 1;
    for (int i = 0; i < WIN; i++) m_window[i] = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: with reset gains the drive is zero; the error is read off.
    rows[0] = '{32'sd0, 0, 1, '{32'sd0, 32'sd0, 32'sd0}};
    rows[1] = '{32'sh7FFF_FFFF, 0, 0, '0};
    rows[2] = '{32'sh8000_0000, 0, 0, '0};
    rows[3] = '{32'sh0001_0000, 1, 1, '{32'sd0, -32'sh0001_0000, 32'sd0}};
    rows[4] = '{-32'sh0003_0000, 0, 0, '0};
    rows[5] = '{32'sd1, 0, 0, '0};
    rows[6] = '{32'sh8000_0000, 1, 1, '{32'sd0, 32'sh7FFF_FFFF, 32'sd0}};
    rows[7] = '{32'sh7FFF_FFFF, 0, 0, '0};
    rows[8] = '{32'sd0, 0, 0, '0};
    rows[9] = '{-32'sd1, 0, 0, '0};
    rows[10] = '{32'sh0010_0000, 0, 0, '0};
    rows[11] = '{32'sh0010_0000, 0, 0, '0};
    for (int i = 0; i < 12; i++) begin
      w.measured_value = rows[i].meas;
      w.restart = rows[i].restart;
      send_sample(w, 1'b0);
      if (rows[i].known) begin
        got = expected_words[$];
        if (got !== rows[i].want) begin
          $error("drive/error_now/integral_now: expected %h actual model %h",
                 rows[i].want, got);
          n_fail++;
        end
      end
    end
    drain_results();

    // Extreme settings: large gains, zero limit and zero period, unknown index.
    write_reg(pwi_pkg::CFG_TARGET, 32'h8000_0000);
    write_reg(pwi_pkg::CFG_LIMIT, 32'h0);
    write_reg(pwi_pkg::CFG_GAIN_P, 32'h7FFF_FFFF);
    write_reg(pwi_pkg::CFG_GAIN_I, 32'h8000_0000);
    write_reg(pwi_pkg::CFG_GAIN_D, 32'h7FFF_FFFF);
    write_reg(pwi_pkg::CFG_PERIOD, 32'h0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    for (int i = 0; i < 25; i++) begin
      w.measured_value = rand_word();
      w.restart = ($urandom_range(0, 15) == 0);
      send_sample(w, 1'b1);
    end
    drain_results();

    // Random phases: fresh settings each phase; restarts are rare so windows fill.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(pwi_pkg::CFG_TARGET, (ph == 7) ? 32'h7FFF_FFFF : rand_word());
      write_reg(pwi_pkg::CFG_LIMIT, (ph == 6) ? 32'h7FFF_FFFF : rand_word() >> 1);
      write_reg(pwi_pkg::CFG_GAIN_P,
                (ph < 4) ? $urandom_range(0, 32'h4_0000) : rand_word());
      write_reg(pwi_pkg::CFG_GAIN_I,
                (ph < 4) ? $urandom_range(0, 32'h4_0000) : rand_word());
      write_reg(pwi_pkg::CFG_GAIN_D,
                (ph < 4) ? $urandom_range(0, 32'h1000) : rand_word());
      write_reg(pwi_pkg::CFG_PERIOD,
                (ph == 5) ? 32'hFFFF_FFFF : (ph == 4) ? 32'd1 : rand_word());
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        w.measured_value = (ph < 4) ? $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh80_0000
                                    : rand_word();
        w.restart = ($urandom_range(0, 40) == 0);
        send_sample(w, (i % 50) < 35);
      end
      drain_results();
    end

    $display("Covered %0d samples and %0d checked results over directed and eight",
             n_sent, n_checked);
    $display("random settings phases, with extreme gains, limits and periods.");
    if (n_fail == 0 && expected_words.size() == 0) begin
      $display("pid_windowed_integral regression: pass");
    end else begin
      $display("pid_windowed_integral regression: fail");
    end
    $finish;
  end

endmodule
